// ===== hw/rtl/three_lane_join_fifo_macros.svh =====
// ----------------------------------------------------------------------------
// three lane join fifo assertion macros
// clocked assertion helpers shared by the checker
// ----------------------------------------------------------------------------
`ifndef THREE_LANE_JOIN_FIFO_MACROS_SVH
`define THREE_LANE_JOIN_FIFO_MACROS_SVH

// checked only outside reset
`define TJF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked during reset as well
`define TJF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tjf_pkg.sv =====
// ----------------------------------------------------------------------------
// tjf_pkg
// shared types and constants of the three lane join fifo
// ----------------------------------------------------------------------------
package tjf_pkg;

    localparam int LANE_COUNT     = 3;
    localparam int LANE_DEPTH_DEF = 16;
    localparam int VALUE_W        = 32;
    localparam int CAP_W          = 5;
    localparam int LANE_W         = 2;
    localparam int STATUS_W       = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_PUSH_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_DONE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LANE_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_LANE_EMPTY = 2'd3;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

    typedef struct packed {
        logic push;
        logic pop;
    } t_lane_ctrl;

endpackage

// ===== hw/rtl/tjf_cell.sv =====
// ----------------------------------------------------------------------------
// tjf_cell
// one storage cell of a lane; loads a pushed value or takes its neighbor's
// ----------------------------------------------------------------------------
module tjf_cell (
    input  logic                                   i_clk,
    input  tjf_pkg::t_cell_ctrl                    i_ctrl,
    input  logic signed [tjf_pkg::VALUE_W-1:0]     i_load_data,
    input  logic signed [tjf_pkg::VALUE_W-1:0]     i_next_data,
    output logic signed [tjf_pkg::VALUE_W-1:0]     o_data
);

    logic signed [tjf_pkg::VALUE_W-1:0] r_data;
    logic signed [tjf_pkg::VALUE_W-1:0] n_data;

    always_comb begin
        priority if (i_ctrl.load) begin
            n_data = i_load_data;
        end else if (i_ctrl.shift) begin
            n_data = i_next_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/tjf_lane.sv =====
// ----------------------------------------------------------------------------
// tjf_lane
// one fifo lane built as a chain of cells with its fill count
// ----------------------------------------------------------------------------
module tjf_lane #(
    parameter int LANE_DEPTH = tjf_pkg::LANE_DEPTH_DEF,
    parameter int FILL_W     = $clog2(LANE_DEPTH + 1)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tjf_pkg::t_lane_ctrl                    i_ctrl,
    input  logic signed [tjf_pkg::VALUE_W-1:0]     i_push_value,
    output logic signed [tjf_pkg::VALUE_W-1:0]     o_head,
    output logic [FILL_W-1:0]                      o_fill
);

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;

    logic signed [tjf_pkg::VALUE_W-1:0] cell_data [LANE_DEPTH];

    for (genvar k = 0; k < LANE_DEPTH; k++) begin : g_cell
        tjf_pkg::t_cell_ctrl                 cell_ctrl;
        logic signed [tjf_pkg::VALUE_W-1:0]  next_data;

        assign cell_ctrl.load  = i_ctrl.push && (r_fill == FILL_W'(k));
        assign cell_ctrl.shift = i_ctrl.pop;

        if (k == LANE_DEPTH - 1) begin : g_last
            assign next_data = cell_data[k];
        end else begin : g_mid
            assign next_data = cell_data[k+1];
        end

        tjf_cell u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (cell_ctrl),
            .i_load_data (i_push_value),
            .i_next_data (next_data),
            .o_data      (cell_data[k])
        );
    end

    always_comb begin
        priority if (i_ctrl.push) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (i_ctrl.pop) begin
            n_fill = r_fill - FILL_W'(1);
        end else begin
            n_fill = r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_head = cell_data[0];
    assign o_fill = r_fill;

endmodule

// ===== hw/rtl/three_lane_join_fifo.sv =====
// result: status and heads are registered when the request is accepted
// throughput: one request per cycle unless stalled; each lane is a chain of
//   cells that shifts toward the head on a pop and loads the tail cell on a push
// reset: fill counts cleared, capacity 16, no result pending; lane contents
//   stay undefined until pushed
// ----------------------------------------------------------------------------
// three_lane_join_fifo
// three fifo lanes with a per-lane capacity limit common to all lanes and a joined triple pop
// ----------------------------------------------------------------------------
module three_lane_join_fifo #(
    parameter int LANE_DEPTH = tjf_pkg::LANE_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic                                   i_cmd,
    input  logic [tjf_pkg::LANE_W-1:0]             i_lane,
    input  logic signed [tjf_pkg::VALUE_W-1:0]     i_push_value,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [tjf_pkg::STATUS_W-1:0]           o_status,
    output logic signed [tjf_pkg::VALUE_W-1:0]     o_head_first,
    output logic signed [tjf_pkg::VALUE_W-1:0]     o_head_second,
    output logic signed [tjf_pkg::VALUE_W-1:0]     o_head_third,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [tjf_pkg::CAP_W-1:0]              i_cfg_lane_capacity
);

    localparam int FILL_W = $clog2(LANE_DEPTH + 1);
    localparam int CMP_W  = (FILL_W > tjf_pkg::CAP_W) ? FILL_W : tjf_pkg::CAP_W;
    localparam logic [CMP_W-1:0] DEPTH_LIMIT = CMP_W'(LANE_DEPTH);

    logic [tjf_pkg::CAP_W-1:0]           r_lane_capacity;
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic [tjf_pkg::STATUS_W-1:0]        r_status;
    logic [tjf_pkg::STATUS_W-1:0]        n_status;
    logic signed [tjf_pkg::VALUE_W-1:0]  r_head [tjf_pkg::LANE_COUNT];
    logic signed [tjf_pkg::VALUE_W-1:0]  n_head [tjf_pkg::LANE_COUNT];

    logic signed [tjf_pkg::VALUE_W-1:0]  lane_head [tjf_pkg::LANE_COUNT];
    logic [FILL_W-1:0]                   lane_fill [tjf_pkg::LANE_COUNT];
    tjf_pkg::t_lane_ctrl                 lane_ctrl [tjf_pkg::LANE_COUNT];

    logic              accept;
    logic              lane_ok;
    logic [FILL_W-1:0] fill_sel;
    logic              lane_full;
    logic              all_ready;
    logic              push_ok;
    logic              pop_ok;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        unique case (i_lane)
            2'd0: begin
                fill_sel = lane_fill[0];
                lane_ok  = 1'b1;
            end
            2'd1: begin
                fill_sel = lane_fill[1];
                lane_ok  = 1'b1;
            end
            2'd2: begin
                fill_sel = lane_fill[2];
                lane_ok  = 1'b1;
            end
            default: begin
                fill_sel = '0;
                lane_ok  = 1'b0;
            end
        endcase
    end

    assign lane_full = !lane_ok
                    || (CMP_W'(fill_sel) >= CMP_W'(r_lane_capacity))
                    || (CMP_W'(fill_sel) >= DEPTH_LIMIT);
    assign all_ready = (lane_fill[0] != '0) && (lane_fill[1] != '0)
                    && (lane_fill[2] != '0);
    assign push_ok   = accept && (i_cmd == tjf_pkg::CMD_PUSH) && !lane_full;
    assign pop_ok    = accept && (i_cmd == tjf_pkg::CMD_POP) && all_ready;

    for (genvar l = 0; l < tjf_pkg::LANE_COUNT; l++) begin : g_lane
        assign lane_ctrl[l].push = push_ok && (i_lane == tjf_pkg::LANE_W'(l));
        assign lane_ctrl[l].pop  = pop_ok;
        assign n_head[l] = pop_ok ? lane_head[l] : '0;

        tjf_lane #(
            .LANE_DEPTH (LANE_DEPTH),
            .FILL_W     (FILL_W)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (lane_ctrl[l]),
            .i_push_value (i_push_value),
            .o_head       (lane_head[l]),
            .o_fill       (lane_fill[l])
        );
    end

    always_comb begin
        priority if (i_cmd == tjf_pkg::CMD_PUSH) begin
            n_status = lane_full ? tjf_pkg::ST_LANE_FULL : tjf_pkg::ST_PUSH_DONE;
        end else begin
            n_status = all_ready ? tjf_pkg::ST_POP_DONE : tjf_pkg::ST_LANE_EMPTY;
        end
    end

    always_comb begin
        priority if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_lane_capacity <= tjf_pkg::CAP_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lane_capacity <= i_cfg_lane_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_head   <= n_head;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_head_first  = r_head[0];
    assign o_head_second = r_head[1];
    assign o_head_third  = r_head[2];

endmodule

// ===== hw/rtl/tjf_checker.sv =====
// ----------------------------------------------------------------------------
// tjf_checker
// port level checks of the three lane join fifo
// ----------------------------------------------------------------------------
`include "three_lane_join_fifo_macros.svh"

module tjf_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_in_valid,
    input logic                                   o_in_stall,
    input logic                                   o_out_valid,
    input logic                                   i_out_stall,
    input logic [tjf_pkg::STATUS_W-1:0]           o_status,
    input logic signed [tjf_pkg::VALUE_W-1:0]     o_head_first,
    input logic signed [tjf_pkg::VALUE_W-1:0]     o_head_second,
    input logic signed [tjf_pkg::VALUE_W-1:0]     o_head_third
);

    logic                                           in_accept;
    logic                                           out_blocked;
    logic                                           non_pop;
    logic                                           heads_zero;
    logic [tjf_pkg::STATUS_W+3*tjf_pkg::VALUE_W-1:0] out_word;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_blocked = o_out_valid && i_out_stall;
    assign non_pop     = o_out_valid && (o_status != tjf_pkg::ST_POP_DONE);
    assign heads_zero  = (o_head_first == '0) && (o_head_second == '0)
                      && (o_head_third == '0);
    assign out_word    = {o_status, o_head_first, o_head_second, o_head_third};

    `TJF_ASSERT_RST(a_reset_idle, !i_rst_n |=> !o_out_valid, "result pending after reset")

    `TJF_ASSERT(a_stall_source, o_in_stall |-> out_blocked, "stall without a blocked result")

    `TJF_ASSERT(a_accept_result, in_accept |=> o_out_valid, "accepted request gave no result")

    `TJF_ASSERT(a_zero_heads, non_pop |-> heads_zero, "heads not zero outside a pop")

    `TJF_ASSERT(a_result_hold, out_blocked |=> o_out_valid && $stable(out_word), "held result changed")

endmodule

bind three_lane_join_fifo tjf_checker u_tjf_checker (.*);

// ===== tb/sv/tjf_join_check.sv =====
// ----------------------------------------------------------------------------
// tjf_join_check
// watches the request, result and capacity channels of the three lane join
// fifo, keeps its own copy of the lanes and the capacity, predicts the
// status and head triple of every accepted request and compares each
// accepted result with the oldest prediction still waiting
// ----------------------------------------------------------------------------
module tjf_join_check
    import tjf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_cmd,
    input  logic [LANE_W-1:0]     i_lane,
    input  logic [VALUE_W-1:0]    i_push_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [VALUE_W-1:0]    i_head_first,
    input  logic [VALUE_W-1:0]    i_head_second,
    input  logic [VALUE_W-1:0]    i_head_third,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CAP_W-1:0]      i_cfg_lane_capacity,
    output int                    o_mismatch_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  head_first;
        logic [VALUE_W-1:0]  head_second;
        logic [VALUE_W-1:0]  head_third;
    } t_join_result;

    logic [VALUE_W-1:0] lane_word [LANE_COUNT][LANE_DEPTH_DEF];
    int                 lane_fill [LANE_COUNT];
    logic [CAP_W-1:0]   capacity;
    t_join_result       expected_joins [$];
    int                 mismatch_cnt;

    function automatic t_join_result predict_join(input logic cmd,
                                                  input logic [LANE_W-1:0] lane,
                                                  input logic [VALUE_W-1:0] value);
        t_join_result r;
        int           eff_cap;
        r       = '0;
        eff_cap = (capacity > LANE_DEPTH_DEF) ? LANE_DEPTH_DEF : int'(capacity);
        if (cmd == CMD_PUSH) begin
            if (lane >= LANE_COUNT || lane_fill[lane] >= eff_cap) begin
                r.status = ST_LANE_FULL;
            end else begin
                lane_word[lane][lane_fill[lane]] = value;
                lane_fill[lane]++;
                r.status = ST_PUSH_DONE;
            end
        end else begin
            if (lane_fill[0] == 0 || lane_fill[1] == 0 || lane_fill[2] == 0) begin
                r.status = ST_LANE_EMPTY;
            end else begin
                r.status      = ST_POP_DONE;
                r.head_first  = lane_word[0][0];
                r.head_second = lane_word[1][0];
                r.head_third  = lane_word[2][0];
                for (int l = 0; l < LANE_COUNT; l++) begin
                    for (int k = 1; k < lane_fill[l]; k++)
                        lane_word[l][k-1] = lane_word[l][k];
                    lane_fill[l]--;
                end
            end
        end
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input t_join_result exp_r,
                                          input t_join_result got_r);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s: expected status %0d heads %h %h %h, got status %0d heads %h %h %h",
                     what, exp_r.status, exp_r.head_first, exp_r.head_second,
                     exp_r.head_third, got_r.status, got_r.head_first, got_r.head_second,
                     got_r.head_third);
    endfunction

    always @(posedge i_clk) begin
        t_join_result got_r;
        t_join_result exp_r;
        if (!i_rst_n) begin
            for (int l = 0; l < LANE_COUNT; l++)
                lane_fill[l] = 0;
            capacity = CAP_RESET;
            expected_joins.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got_r = {i_status, i_head_first, i_head_second, i_head_third};
                if (expected_joins.size() == 0) begin
                    note_mismatch("result with no request waiting", '0, got_r);
                end else begin
                    exp_r = expected_joins.pop_front();
                    if (got_r.status !== exp_r.status ||
                        got_r.head_first !== exp_r.head_first ||
                        got_r.head_second !== exp_r.head_second ||
                        got_r.head_third !== exp_r.head_third)
                        note_mismatch("join result mismatch", exp_r, got_r);
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                capacity = i_cfg_lane_capacity;
            if (i_in_valid && !i_in_stall)
                expected_joins.push_back(predict_join(i_cmd, i_lane, i_push_value));
        end
        o_pending        <= expected_joins.size();
        o_mismatch_count <= mismatch_cnt;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives the three lane join fifo with a directed run of pushes and pops
// around the capacity corners, then random request streams under several
// capacity settings and idle patterns, with one long hold-off on the result
// side; a separate checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import tjf_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int PHASE_COUNT     = 9;
    localparam int PHASE_REQUESTS  = 140;
    localparam int LONG_HOLD_CYCLES = 80;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                in_cmd = CMD_PUSH;
    logic [LANE_W-1:0]   in_lane = '0;
    logic [VALUE_W-1:0]  in_value = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] out_status;
    logic [VALUE_W-1:0]  out_head_first;
    logic [VALUE_W-1:0]  out_head_second;
    logic [VALUE_W-1:0]  out_head_third;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CAP_W-1:0]    cfg_capacity = CAP_RESET;

    int                  mismatch_count;
    int                  pending;
    int                  in_idle_pct = 22;
    int                  out_idle_pct = 45;
    bit                  long_hold_req = 1'b0;
    int                  push_sent = 0;
    int                  pop_sent = 0;
    int                  cap_writes = 0;
    int                  quiet_cycles = 0;

    always #10 i_clk = ~i_clk;

    three_lane_join_fifo #(
        .LANE_DEPTH (LANE_DEPTH_DEF)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_cmd               (in_cmd),
        .i_lane              (in_lane),
        .i_push_value        (in_value),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_status            (out_status),
        .o_head_first        (out_head_first),
        .o_head_second       (out_head_second),
        .o_head_third        (out_head_third),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_lane_capacity (cfg_capacity)
    );

    tjf_join_check u_join_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_cmd               (in_cmd),
        .i_lane              (in_lane),
        .i_push_value        (in_value),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_status            (out_status),
        .i_head_first        (out_head_first),
        .i_head_second       (out_head_second),
        .i_head_third        (out_head_third),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_lane_capacity (cfg_capacity),
        .o_mismatch_count    (mismatch_count),
        .o_pending           (pending)
    );

    // result side stall, with a one-shot long hold-off
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(99) < out_idle_pct);
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(input logic cmd, input logic [LANE_W-1:0] lane,
                            input logic [VALUE_W-1:0] value);
        logic stalled;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_lane  <= lane;
        in_value <= value;
        do begin
            @(negedge i_clk);
            stalled = in_stall;
            @(posedge i_clk);
        end while (stalled);
        if (cmd == CMD_PUSH)
            push_sent++;
        else
            pop_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        logic ready_seen;
        wait_drained();
        cfg_valid    <= 1'b1;
        cfg_capacity <= cap;
        do begin
            @(negedge i_clk);
            ready_seen = cfg_ready;
            @(posedge i_clk);
        end while (!ready_seen);
        cfg_valid <= 1'b0;
        cap_writes++;
    endtask

    task automatic random_req(input int pop_pct);
        logic               cmd;
        logic [LANE_W-1:0]  lane;
        logic [VALUE_W-1:0] value;
        cmd = ($urandom_range(99) < pop_pct) ? CMD_POP : CMD_PUSH;
        if ($urandom_range(99) < 5)
            lane = 2'd3;
        else
            lane = LANE_W'($urandom_range(LANE_COUNT - 1));
        case ($urandom_range(9))
            0: value = 32'h8000_0000;
            1: value = 32'h7fff_ffff;
            2: value = '0;
            3: value = '1;
            default: value = $urandom;
        endcase
        send_req(cmd, lane, value);
    endtask

    initial begin
        logic [CAP_W-1:0] phase_cap [PHASE_COUNT];
        int               pop_pct;
        phase_cap = '{5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd8, 5'd2, 5'd16, 5'd20};
        phase_cap[5] = CAP_W'($urandom_range(1, 16));
        phase_cap[8] = CAP_W'($urandom_range(0, 31));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty lanes, value extremes, bad lane, partial fill
        send_req(CMD_POP, 2'd0, '0);
        send_req(CMD_PUSH, 2'd0, 32'h8000_0000);
        send_req(CMD_PUSH, 2'd1, 32'h7fff_ffff);
        send_req(CMD_PUSH, 2'd2, 32'h0000_0000);
        send_req(CMD_POP, 2'd3, 32'hffff_ffff);
        send_req(CMD_PUSH, 2'd3, 32'hffff_ffff);
        send_req(CMD_PUSH, 2'd0, 32'hffff_ffff);
        send_req(CMD_PUSH, 2'd1, 32'h0000_0001);
        send_req(CMD_POP, 2'd1, '0);
        send_req(CMD_PUSH, 2'd2, 32'h5555_5555);
        send_req(CMD_PUSH, 2'd2, 32'haaaa_aaaa);
        send_req(CMD_POP, 2'd2, '0);

        // capacity lowered to a lane's fill
        write_capacity(5'd1);
        send_req(CMD_PUSH, 2'd2, 32'h1234_5678);
        send_req(CMD_PUSH, 2'd0, 32'h0000_0002);
        send_req(CMD_PUSH, 2'd0, 32'h0000_0003);
        send_req(CMD_PUSH, 2'd1, 32'h0000_0004);
        send_req(CMD_POP, 2'd0, '0);

        // zero capacity refuses every push
        write_capacity(5'd0);
        send_req(CMD_PUSH, 2'd1, 32'hdead_beef);
        send_req(CMD_POP, 2'd0, '0);

        // capacity above the lane depth
        write_capacity(5'd31);
        send_req(CMD_PUSH, 2'd0, 32'h0000_0007);
        send_req(CMD_PUSH, 2'd1, 32'h0000_0008);
        send_req(CMD_PUSH, 2'd2, 32'h0000_0009);
        send_req(CMD_POP, 2'd0, '0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_capacity(phase_cap[p]);
            case (p / 3)
                0: begin
                    in_idle_pct  = 22;
                    out_idle_pct = 45;
                end
                1: begin
                    in_idle_pct  = 45;
                    out_idle_pct = 22;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            if (p == 0)
                long_hold_req = 1'b1;
            pop_pct = $urandom_range(15, 50);
            for (int i = 0; i < PHASE_REQUESTS; i++)
                random_req(pop_pct);
        end

        wait_drained();
        repeat (5) @(posedge i_clk);
        $display("ran %0d pushes and %0d pops under %0d capacity writes", push_sent, pop_sent,
                 cap_writes);
        $display("capacities covered zero, one, full depth and above depth, with stalls");
        if (mismatch_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
